FILE: src/m2a_pkg.sv
`default_nettype none
package m2a_pkg;

  localparam int unsigned MAX_TAPS_DEF = 4;

  localparam int unsigned THR_W     = 16;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned MOTION_W  = 16;
  localparam int unsigned PC_W      = 4;
  localparam int unsigned CFG_ADR_W = 3;

  localparam logic [THR_W-1:0] THR_RESET = 16'd60;

  typedef enum logic [1:0] {
    REQ_X     = 2'd0,
    REQ_Y     = 2'd1,
    REQ_OTHER = 2'd2,
    REQ_SPARE = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_SPARE   = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    ARROW_UP    = 2'd0,
    ARROW_DOWN  = 2'd1,
    ARROW_LEFT  = 2'd2,
    ARROW_RIGHT = 2'd3
  } arrow_code_t;

  // config register index
  localparam logic REG_STEP_THRESHOLD = 1'b0;

  // microcode operations
  typedef enum logic [2:0] {
    OP_WAIT    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_DIV     = 3'd2,
    OP_TEST    = 3'd3,
    OP_COMMIT  = 3'd4,
    OP_EMIT    = 3'd5,
    OP_VERDICT = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef logic [PC_W-1:0] pc_t;

  // program steps
  localparam pc_t PC_WAIT = 4'd0;
  localparam pc_t PC_LDY  = 4'd1;
  localparam pc_t PC_DIVY = 4'd2;
  localparam pc_t PC_TSTY = 4'd3;
  localparam pc_t PC_LDX  = 4'd4;
  localparam pc_t PC_DIVX = 4'd5;
  localparam pc_t PC_TSTX = 4'd6;
  localparam pc_t PC_CMT  = 4'd7;
  localparam pc_t PC_EMIT = 4'd8;
  localparam pc_t PC_VERD = 4'd9;

  typedef struct packed {
    op_t  op;
    logic axis_y;
    pc_t  nxt;
    pc_t  jmp;
  } ctrl_word_t;

  typedef struct packed {
    logic advance;
    logic jump;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: src/m2a_in_if.sv
`default_nettype none
interface m2a_in_if;
  import m2a_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic signed [MOTION_W-1:0] motion_value;

  modport source (output valid, output req_type, output motion_value, input ready);
  modport sink (input valid, input req_type, input motion_value, output ready);
endinterface
`default_nettype wire

FILE: src/m2a_out_if.sv
`default_nettype none
interface m2a_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [1:0] arrow_code;
  logic       event_consumed;
  logic       last_of_run;

  modport source (output valid, output result_kind, output arrow_code,
                  output event_consumed, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input arrow_code,
                input event_consumed, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: src/motion_to_arrow_steps.sv
`default_nettype none
// Turns relative pointer motion into arrow key taps. Each input beat is an x motion, a y motion
// or another event. Another event makes the program jump straight to the verdict step, which
// loads one pass-on verdict beat into the output register. A motion beat is worked by a small
// microcoded sequencer that runs a ten-step program over one 32-bit subtract-and-compare
// datapath: one threshold is subtracted per cycle per tap, up to MAX_TAPS taps, and each tap
// gives a press and a release beat. The next input is taken once the program is back at the
// wait step after the verdict. A result beat sits in an output register; a stalled output
// holds the program at the emit or verdict step. The step threshold sits at byte addresses
// 0 to 3 of the config port and must only be written while the block is idle.
module motion_to_arrow_steps #(
  parameter int unsigned MAX_TAPS = m2a_pkg::MAX_TAPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [m2a_pkg::CFG_ADR_W-1:0]    cfg_paddr,
  input  wire logic [31:0]                      cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready,
  m2a_in_if.sink                                in_ch,
  m2a_out_if.source                             out_ch
);
  import m2a_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [THR_W-1:0] thr_nxt;
  logic             reg_hit;
  ctrl_word_t       cw;
  dp_status_t       status;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[CFG_ADR_W-1] == REG_STEP_THRESHOLD);

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      thr_nxt = cfg_pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_hit) begin
      cfg_prdata = {{(32 - THR_W){1'b0}}, thr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  m2a_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cw     (cw)
  );

  m2a_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_threshold (thr_r),
    .cw             (cw),
    .status         (status),
    .in_ch          (in_ch),
    .out_ch         (out_ch)
  );
endmodule
`default_nettype wire

FILE: src/m2a_seq.sv
`default_nettype none
module m2a_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire m2a_pkg::dp_status_t   status,
  output m2a_pkg::ctrl_word_t        cw
);
  import m2a_pkg::*;

  pc_t pc_r;
  pc_t pc_nxt;

  function automatic ctrl_word_t rom_word(input pc_t pc);
    ctrl_word_t w;
    begin
      w = '{op: OP_NOP, axis_y: 1'b0, nxt: PC_WAIT, jmp: PC_WAIT};
      unique case (pc)
        PC_WAIT: w = '{op: OP_WAIT,    axis_y: 1'b0, nxt: PC_LDY,  jmp: PC_VERD};
        PC_LDY:  w = '{op: OP_LOAD,    axis_y: 1'b1, nxt: PC_DIVY, jmp: PC_DIVY};
        PC_DIVY: w = '{op: OP_DIV,     axis_y: 1'b1, nxt: PC_TSTY, jmp: PC_DIVY};
        PC_TSTY: w = '{op: OP_TEST,    axis_y: 1'b1, nxt: PC_LDX,  jmp: PC_CMT};
        PC_LDX:  w = '{op: OP_LOAD,    axis_y: 1'b0, nxt: PC_DIVX, jmp: PC_DIVX};
        PC_DIVX: w = '{op: OP_DIV,     axis_y: 1'b0, nxt: PC_TSTX, jmp: PC_DIVX};
        PC_TSTX: w = '{op: OP_TEST,    axis_y: 1'b0, nxt: PC_VERD, jmp: PC_CMT};
        PC_CMT:  w = '{op: OP_COMMIT,  axis_y: 1'b0, nxt: PC_EMIT, jmp: PC_EMIT};
        PC_EMIT: w = '{op: OP_EMIT,    axis_y: 1'b0, nxt: PC_VERD, jmp: PC_EMIT};
        PC_VERD: w = '{op: OP_VERDICT, axis_y: 1'b0, nxt: PC_WAIT, jmp: PC_WAIT};
        default: w = '{op: OP_NOP,     axis_y: 1'b0, nxt: PC_WAIT, jmp: PC_WAIT};
      endcase
      return w;
    end
  endfunction

  assign cw = rom_word(pc_r);

  always_comb begin
    priority if (status.jump) begin
      pc_nxt = cw.jmp;
    end else if (status.advance) begin
      pc_nxt = cw.nxt;
    end else begin
      pc_nxt = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: src/m2a_dp.sv
`default_nettype none
module m2a_dp #(
  parameter int unsigned MAX_TAPS = m2a_pkg::MAX_TAPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [m2a_pkg::THR_W-1:0]  step_threshold,
  input  wire m2a_pkg::ctrl_word_t        cw,
  output m2a_pkg::dp_status_t             status,
  m2a_in_if.sink                          in_ch,
  m2a_out_if.source                       out_ch
);
  import m2a_pkg::*;

  localparam int unsigned NW = $clog2(MAX_TAPS + 1);

  logic signed [ACC_W-1:0] acc_x_r, acc_x_nxt;
  logic signed [ACC_W-1:0] acc_y_r, acc_y_nxt;
  logic [ACC_W-1:0]        mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic                    axis_y_r, axis_y_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic                    ph_r, ph_nxt;
  logic                    cons_r, cons_nxt;

  logic                    ov_r, ov_nxt;
  logic [1:0]              o_kind_r, o_kind_nxt;
  logic [1:0]              o_code_r, o_code_nxt;
  logic                    o_cons_r, o_cons_nxt;
  logic                    o_last_r, o_last_nxt;

  logic [THR_W-1:0]        tick;
  logic                    accept;
  logic                    slot_free;
  logic                    is_motion;
  logic signed [ACC_W-1:0] acc_sel;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sum_sat;
  logic signed [ACC_W-1:0] ld_src;
  logic [ACC_W-1:0]        ld_mag;
  logic [ACC_W-1:0]        cmt_val;
  logic                    div_go;
  logic [1:0]              tap_code;

  assign tick      = (step_threshold == '0) ? THR_W'(1) : step_threshold;
  assign in_ch.ready = (cw.op == OP_WAIT);
  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !ov_r || out_ch.ready;
  assign is_motion = (in_ch.req_type == REQ_X) || (in_ch.req_type == REQ_Y);

  // saturating add of the new motion to its axis
  assign acc_sel = (in_ch.req_type == REQ_Y) ? acc_y_r : acc_x_r;
  assign sum     = {acc_sel[ACC_W-1], acc_sel}
                 + {{(ACC_W + 1 - MOTION_W){in_ch.motion_value[MOTION_W-1]}},
                    in_ch.motion_value};
  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  assign ld_src  = cw.axis_y ? acc_y_r : acc_x_r;
  assign ld_mag  = ld_src[ACC_W-1] ? (~ld_src + ACC_W'(1)) : ld_src;
  assign cmt_val = neg_r ? (~mag_r + ACC_W'(1)) : mag_r;
  assign div_go  = (mag_r >= {{(ACC_W - THR_W){1'b0}}, tick}) && (n_r != NW'(MAX_TAPS));

  always_comb begin
    if (axis_y_r) begin
      tap_code = neg_r ? ARROW_UP : ARROW_DOWN;
    end else begin
      tap_code = neg_r ? ARROW_LEFT : ARROW_RIGHT;
    end
  end

  always_comb begin
    acc_x_nxt  = acc_x_r;
    acc_y_nxt  = acc_y_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    axis_y_nxt = axis_y_r;
    n_nxt      = n_r;
    ph_nxt     = ph_r;
    cons_nxt   = cons_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_kind_nxt = o_kind_r;
    o_code_nxt = o_code_r;
    o_cons_nxt = o_cons_r;
    o_last_nxt = o_last_r;
    status     = '{advance: 1'b0, jump: 1'b0};

    unique case (cw.op)
      OP_WAIT: begin
        if (accept) begin
          if (is_motion) begin
            if (in_ch.req_type == REQ_Y) begin
              acc_y_nxt = sum_sat;
            end else begin
              acc_x_nxt = sum_sat;
            end
            cons_nxt       = 1'b1;
            status.advance = 1'b1;
          end else begin
            cons_nxt    = 1'b0;
            status.jump = 1'b1;
          end
        end
      end
      OP_LOAD: begin
        mag_nxt        = ld_mag;
        neg_nxt        = ld_src[ACC_W-1];
        axis_y_nxt     = cw.axis_y;
        n_nxt          = '0;
        ph_nxt         = 1'b0;
        status.advance = 1'b1;
      end
      OP_DIV: begin
        // one threshold subtracted per step, capped at the tap limit
        if (div_go) begin
          mag_nxt     = mag_r - {{(ACC_W - THR_W){1'b0}}, tick};
          n_nxt       = n_r + NW'(1);
          status.jump = 1'b1;
        end else begin
          status.advance = 1'b1;
        end
      end
      OP_TEST: begin
        if (n_r != '0) begin
          status.jump = 1'b1;
        end else begin
          status.advance = 1'b1;
        end
      end
      OP_COMMIT: begin
        // remainder goes back, the other axis is locked out
        if (axis_y_r) begin
          acc_y_nxt = cmt_val;
          acc_x_nxt = '0;
        end else begin
          acc_x_nxt = cmt_val;
          acc_y_nxt = '0;
        end
        status.advance = 1'b1;
      end
      OP_EMIT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          o_kind_nxt = ph_r ? KIND_RELEASE : KIND_PRESS;
          o_code_nxt = tap_code;
          o_cons_nxt = 1'b0;
          o_last_nxt = 1'b0;
          ph_nxt     = !ph_r;
          if (ph_r) begin
            n_nxt = n_r - NW'(1);
            if (n_r == NW'(1)) begin
              status.advance = 1'b1;
            end
          end
        end
      end
      OP_VERDICT: begin
        if (slot_free) begin
          ov_nxt         = 1'b1;
          o_kind_nxt     = KIND_VERDICT;
          o_code_nxt     = ARROW_UP;
          o_cons_nxt     = cons_r;
          o_last_nxt     = 1'b1;
          status.advance = 1'b1;
        end
      end
      OP_NOP: begin
        status.advance = 1'b1;
      end
      default: begin
        status.advance = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      ov_r    <= 1'b0;
      n_r     <= '0;
      ph_r    <= 1'b0;
      cons_r  <= 1'b0;
    end else begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      ov_r    <= ov_nxt;
      n_r     <= n_nxt;
      ph_r    <= ph_nxt;
      cons_r  <= cons_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    axis_y_r <= axis_y_nxt;
    o_kind_r <= o_kind_nxt;
    o_code_r <= o_code_nxt;
    o_cons_r <= o_cons_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.result_kind    = o_kind_r;
  assign out_ch.arrow_code     = o_code_r;
  assign out_ch.event_consumed = o_cons_r;
  assign out_ch.last_of_run    = o_last_r;
endmodule
`default_nettype wire
